// ===== rtl/core/dzvf_pkg.sv =====
package dzvf_pkg;

  localparam int unsigned IterW = 5;
  localparam logic [IterW-1:0] IterLast = IterW'(31);

  typedef enum logic [1:0] {
    CFG_DEAD_ZONE_X    = 2'd0,
    CFG_DEAD_ZONE_Y    = 2'd1,
    CFG_SPEED_LIMIT_ON = 2'd2,
    CFG_MAX_SPEED      = 2'd3
  } dzvf_cfg_e;

  typedef enum logic [2:0] {
    STATUS_OK         = 3'd0,
    STATUS_BAD_VIEW   = 3'd1,
    STATUS_BAD_BOUNDS = 3'd2,
    STATUS_BAD_DELTA  = 3'd3
  } dzvf_status_e;

  typedef enum logic {
    ITEM_FOLLOW = 1'b0,
    ITEM_SNAP   = 1'b1
  } dzvf_item_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_TRAIL, OP_MAXD, OP_SQX, OP_SQY, OP_MD2, OP_SQRT_INIT,
    OP_SQRT_STEP, OP_PX, OP_PY, OP_DIV_STEP, OP_MOVE, OP_COMMIT, OP_LERP_X, OP_LERP_Y
  } dzvf_op_e;

  typedef struct packed {
    logic               op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [30:0] view_half_x;
    logic        [30:0] view_half_y;
    logic               bounds_on;
    logic signed [31:0] bounds_min_x;
    logic signed [31:0] bounds_min_y;
    logic signed [31:0] bounds_max_x;
    logic signed [31:0] bounds_max_y;
    logic        [15:0] delta_time;
    logic        [16:0] interp_frac;
  } dzvf_in_t;

  typedef struct packed {
    logic        [2:0]  status;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] interp_x;
    logic signed [31:0] interp_y;
  } dzvf_out_t;

  typedef struct packed {
    dzvf_op_e op;
    logic     out_load;
  } dzvf_cmd_t;

  typedef struct packed {
    logic err;
    logic snap;
    logic limit_en;
    logic limit;
  } dzvf_stat_t;

endpackage

// ===== rtl/core/dzvf_if.sv =====
interface dzvf_in_if import dzvf_pkg::*; ();
  logic     valid;
  logic     ready;
  dzvf_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dzvf_out_if import dzvf_pkg::*; ();
  logic      valid;
  logic      ready;
  dzvf_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/dzvf_datapath.sv =====
module dzvf_datapath import dzvf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  input  dzvf_in_t    in_data_i,
  input  dzvf_cmd_t   cmd_i,
  output dzvf_stat_t  stat_o,
  output dzvf_out_t   out_data_o
);

  function automatic logic signed [31:0] trail_axis(input logic signed [31:0] cur,
                                                     input logic signed [31:0] t,
                                                     input logic [30:0] dz);
    logic signed [33:0] lo, hi, tt, up, dn;
    logic signed [31:0] res;
    lo  = {{2{cur[31]}}, cur} - {3'b000, dz};
    hi  = {{2{cur[31]}}, cur} + {3'b000, dz};
    tt  = {{2{t[31]}}, t};
    up  = tt + {3'b000, dz};
    dn  = tt - {3'b000, dz};
    res = cur;
    if (tt < lo) begin
      res = up[31:0];
    end else if (tt > hi) begin
      res = dn[31:0];
    end
    return res;
  endfunction

  function automatic logic signed [31:0] clamp_axis(input logic signed [31:0] v,
                                                     input logic signed [31:0] lo,
                                                     input logic signed [31:0] hi,
                                                     input logic [30:0] half);
    logic signed [33:0] cmin, cmax, vv;
    logic signed [32:0] sum;
    logic signed [31:0] res;
    cmin = {{2{lo[31]}}, lo} + {3'b000, half};
    cmax = {{2{hi[31]}}, hi} - {3'b000, half};
    vv   = {{2{v[31]}}, v};
    sum  = {lo[31], lo} + {hi[31], hi};
    res  = v;
    if (cmin > cmax) begin
      res = sum[32:1];
    end else if (vv < cmin) begin
      res = cmin[31:0];
    end else if (vv > cmax) begin
      res = cmax[31:0];
    end
    return res;
  endfunction

  function automatic logic [64:0] div_step(input logic [32:0] r, input logic [31:0] l,
                                           input logic [31:0] d);
    logic [32:0] t;
    logic        qb;
    t  = {r[31:0], l[31]};
    qb = (t >= {1'b0, d});
    if (qb) begin
      t = t - {1'b0, d};
    end
    return {t, l[30:0], qb};
  endfunction

  // configuration
  logic [30:0] dz_x_q, dz_y_q, max_speed_q;
  logic        limit_on_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_x_q      <= '0;
      dz_y_q      <= '0;
      limit_on_q  <= 1'b0;
      max_speed_q <= 31'd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEAD_ZONE_X:    dz_x_q      <= cfg_data_i;
        CFG_DEAD_ZONE_Y:    dz_y_q      <= cfg_data_i;
        CFG_SPEED_LIMIT_ON: limit_on_q  <= cfg_data_i[0];
        CFG_MAX_SPEED:      max_speed_q <= cfg_data_i;
        default:            ;
      endcase
    end
  end

  // view state
  logic signed [31:0] cur_x_q, cur_y_q, prev_x_q, prev_y_q;
  logic signed [31:0] cur_x_d, cur_y_d, prev_x_d, prev_y_d;

  // item words
  logic               op_q, bon_q;
  logic signed [31:0] px_q, py_q, bminx_q, bminy_q, bmaxx_q, bmaxy_q;
  logic        [30:0] hx_q, hy_q;
  logic        [16:0] frac_q;
  logic        [2:0]  status_q;

  // working values
  logic signed [31:0] nx_q, ny_q, ix_q, iy_q;
  logic        [30:0] sx_q, sy_q, maxd_q;
  logic               sgnx_q, sgny_q, shf_q;
  logic        [61:0] sqx_q, sqy_q, md2_q;
  logic        [63:0] sqn_q, sqr_q, sqb_q;
  logic        [32:0] drx_q, dry_q;
  logic        [31:0] dlx_q, dly_q;
  logic        [15:0] delta_q;

  logic [2:0] status_d;
  always_comb begin
    status_d = STATUS_OK;
    if (in_data_i.view_half_x == '0 || in_data_i.view_half_y == '0) begin
      status_d = STATUS_BAD_VIEW;
    end else if (in_data_i.bounds_on &&
                 (in_data_i.bounds_min_x > in_data_i.bounds_max_x ||
                  in_data_i.bounds_min_y > in_data_i.bounds_max_y)) begin
      status_d = STATUS_BAD_BOUNDS;
    end else if (in_data_i.op == ITEM_FOLLOW && in_data_i.delta_time == '0) begin
      status_d = STATUS_BAD_DELTA;
    end
  end

  // shared unsigned multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  always_comb begin
    mul_a = {1'b0, sx_q};
    mul_b = {1'b0, sx_q};
    case (cmd_i.op)
      OP_MAXD: begin
        mul_a = {1'b0, max_speed_q};
        mul_b = {16'b0, delta_q};
      end
      OP_SQY: begin
        mul_a = {1'b0, sy_q};
        mul_b = {1'b0, sy_q};
      end
      OP_MD2: begin
        mul_a = {1'b0, maxd_q};
        mul_b = {1'b0, maxd_q};
      end
      OP_PX: begin
        mul_a = {1'b0, sx_q};
        mul_b = {1'b0, maxd_q};
      end
      OP_PY: begin
        mul_a = {1'b0, sy_q};
        mul_b = {1'b0, maxd_q};
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // shared signed multiplier for interpolation
  logic signed [32:0] lerp_diff;
  logic signed [31:0] lerp_base;
  logic signed [50:0] lerp_p;
  logic signed [31:0] lerp_r;
  always_comb begin
    if (cmd_i.op == OP_LERP_Y) begin
      lerp_diff = {cur_y_q[31], cur_y_q} - {prev_y_q[31], prev_y_q};
      lerp_base = prev_y_q;
    end else begin
      lerp_diff = {cur_x_q[31], cur_x_q} - {prev_x_q[31], prev_x_q};
      lerp_base = prev_x_q;
    end
    lerp_p = lerp_diff * $signed({1'b0, frac_q});
    lerp_r = lerp_base + lerp_p[47:16];
  end

  // trail and move offsets
  logic signed [31:0] tx, ty;
  logic signed [32:0] dx, dy;
  logic        [32:0] ax, ay, shx, shy;
  logic               sh1, sh2;
  always_comb begin
    tx  = trail_axis(cur_x_q, px_q, dz_x_q);
    ty  = trail_axis(cur_y_q, py_q, dz_y_q);
    dx  = {tx[31], tx} - {cur_x_q[31], cur_x_q};
    dy  = {ty[31], ty} - {cur_y_q[31], cur_y_q};
    ax  = dx[32] ? 33'(-dx) : 33'(dx);
    ay  = dy[32] ? 33'(-dy) : 33'(dy);
    sh2 = ax[32] | ay[32];
    sh1 = ax[31] | ay[31];
    shx = sh2 ? (ax >> 2) : (sh1 ? (ax >> 1) : ax);
    shy = sh2 ? (ay >> 2) : (sh1 ? (ay >> 1) : ay);
  end

  logic [63:0] sq_t;
  logic [64:0] dvx, dvy;
  logic signed [32:0] mvx, mvy;
  logic signed [31:0] clx, cly;
  always_comb begin
    sq_t = sqr_q + sqb_q;
    dvx  = div_step(drx_q, dlx_q, sqr_q[31:0]);
    dvy  = div_step(dry_q, dly_q, sqr_q[31:0]);
    mvx  = sgnx_q ? ({cur_x_q[31], cur_x_q} - {1'b0, dlx_q})
                  : ({cur_x_q[31], cur_x_q} + {1'b0, dlx_q});
    mvy  = sgny_q ? ({cur_y_q[31], cur_y_q} - {1'b0, dly_q})
                  : ({cur_y_q[31], cur_y_q} + {1'b0, dly_q});
    clx  = bon_q ? clamp_axis(nx_q, bminx_q, bmaxx_q, hx_q) : nx_q;
    cly  = bon_q ? clamp_axis(ny_q, bminy_q, bmaxy_q, hy_q) : ny_q;
  end

  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    prev_x_d = prev_x_q;
    prev_y_d = prev_y_q;
    if (cmd_i.op == OP_COMMIT) begin
      cur_x_d  = clx;
      cur_y_d  = cly;
      prev_x_d = op_q ? clx : cur_x_q;
      prev_y_d = op_q ? cly : cur_y_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      prev_x_q <= '0;
      prev_y_q <= '0;
    end else begin
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      prev_x_q <= prev_x_d;
      prev_y_q <= prev_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        op_q     <= in_data_i.op;
        px_q     <= in_data_i.pos_x;
        py_q     <= in_data_i.pos_y;
        hx_q     <= in_data_i.view_half_x;
        hy_q     <= in_data_i.view_half_y;
        bon_q    <= in_data_i.bounds_on;
        bminx_q  <= in_data_i.bounds_min_x;
        bminy_q  <= in_data_i.bounds_min_y;
        bmaxx_q  <= in_data_i.bounds_max_x;
        bmaxy_q  <= in_data_i.bounds_max_y;
        delta_q  <= in_data_i.delta_time;
        frac_q   <= (in_data_i.interp_frac > 17'd65536) ? 17'd65536
                                                        : in_data_i.interp_frac;
        status_q <= status_d;
        nx_q     <= in_data_i.pos_x;
        ny_q     <= in_data_i.pos_y;
      end
      OP_TRAIL: begin
        nx_q   <= tx;
        ny_q   <= ty;
        sx_q   <= shx[30:0];
        sy_q   <= shy[30:0];
        sgnx_q <= dx[32];
        sgny_q <= dy[32];
        shf_q  <= sh1 | sh2;
      end
      OP_MAXD: maxd_q <= mul_p[46:16];
      OP_SQX:  sqx_q  <= mul_p[61:0];
      OP_SQY:  sqy_q  <= mul_p[61:0];
      OP_MD2:  md2_q  <= mul_p[61:0];
      OP_SQRT_INIT: begin
        sqn_q <= {2'b00, sqx_q} + {2'b00, sqy_q};
        sqr_q <= '0;
        sqb_q <= 64'h4000_0000_0000_0000;
      end
      OP_SQRT_STEP: begin
        if (sqn_q >= sq_t) begin
          sqn_q <= sqn_q - sq_t;
          sqr_q <= (sqr_q >> 1) + sqb_q;
        end else begin
          sqr_q <= sqr_q >> 1;
        end
        sqb_q <= sqb_q >> 2;
      end
      OP_PX: begin
        drx_q <= {1'b0, mul_p[63:32]};
        dlx_q <= mul_p[31:0];
      end
      OP_PY: begin
        dry_q <= {1'b0, mul_p[63:32]};
        dly_q <= mul_p[31:0];
      end
      OP_DIV_STEP: begin
        drx_q <= dvx[64:32];
        dlx_q <= dvx[31:0];
        dry_q <= dvy[64:32];
        dly_q <= dvy[31:0];
      end
      OP_MOVE: begin
        if (sqr_q[31:0] != '0) begin
          nx_q <= mvx[31:0];
          ny_q <= mvy[31:0];
        end
      end
      OP_LERP_X: ix_q <= lerp_r;
      OP_LERP_Y: iy_q <= lerp_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_o.status   <= status_q;
      out_data_o.center_x <= cur_x_q;
      out_data_o.center_y <= cur_y_q;
      out_data_o.interp_x <= ix_q;
      out_data_o.interp_y <= iy_q;
    end
  end

  assign stat_o.err      = (status_q != STATUS_OK);
  assign stat_o.snap     = (op_q == ITEM_SNAP);
  assign stat_o.limit_en = limit_on_q;
  assign stat_o.limit    = shf_q ||
                           (({2'b00, sqx_q} + {2'b00, sqy_q}) > {2'b00, md2_q});

endmodule

// ===== rtl/core/dzvf_ctrl.sv =====
module dzvf_ctrl import dzvf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dzvf_stat_t stat_i,
  output dzvf_cmd_t  cmd_o
);

  typedef enum logic [16:0] {
    S_IDLE  = 17'b00000000000000001,
    S_DISP  = 17'b00000000000000010,
    S_TRAIL = 17'b00000000000000100,
    S_MAXD  = 17'b00000000000001000,
    S_SQX   = 17'b00000000000010000,
    S_SQY   = 17'b00000000000100000,
    S_MD2   = 17'b00000000001000000,
    S_CMP   = 17'b00000000010000000,
    S_SQRT  = 17'b00000000100000000,
    S_PX    = 17'b00000001000000000,
    S_PY    = 17'b00000010000000000,
    S_DIV   = 17'b00000100000000000,
    S_MOVE  = 17'b00001000000000000,
    S_COMMIT= 17'b00010000000000000,
    S_LERPX = 17'b00100000000000000,
    S_LERPY = 17'b01000000000000000,
    S_OUT   = 17'b10000000000000000
  } dzvf_state_e;

  dzvf_state_e      state_q, state_d;
  logic [IterW-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmd_o.op     = OP_NONE;
    cmd_o.out_load = 1'b0;
    in_ready_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        if (stat_i.err) begin
          state_d = S_LERPX;
        end else if (stat_i.snap) begin
          state_d = S_COMMIT;
        end else begin
          state_d = S_TRAIL;
        end
      end
      S_TRAIL: begin
        cmd_o.op = OP_TRAIL;
        state_d  = stat_i.limit_en ? S_MAXD : S_COMMIT;
      end
      S_MAXD: begin
        cmd_o.op = OP_MAXD;
        state_d  = S_SQX;
      end
      S_SQX: begin
        cmd_o.op = OP_SQX;
        state_d  = S_SQY;
      end
      S_SQY: begin
        cmd_o.op = OP_SQY;
        state_d  = S_MD2;
      end
      S_MD2: begin
        cmd_o.op = OP_MD2;
        state_d  = S_CMP;
      end
      S_CMP: begin
        if (stat_i.limit) begin
          cmd_o.op = OP_SQRT_INIT;
          cnt_d    = '0;
          state_d  = S_SQRT;
        end else begin
          state_d = S_COMMIT;
        end
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == IterLast) begin
          state_d = S_PX;
        end
      end
      S_PX: begin
        cmd_o.op = OP_PX;
        state_d  = S_PY;
      end
      S_PY: begin
        cmd_o.op = OP_PY;
        cnt_d    = '0;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == IterLast) begin
          state_d = S_MOVE;
        end
      end
      S_MOVE: begin
        cmd_o.op = OP_MOVE;
        state_d  = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.op = OP_COMMIT;
        state_d  = S_LERPX;
      end
      S_LERPX: begin
        cmd_o.op = OP_LERP_X;
        state_d  = S_LERPY;
      end
      S_LERPY: begin
        cmd_o.op = OP_LERP_Y;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while busy");

  a_iter_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP && state_d == S_SQRT) |=> (cnt_q == '0))
    else $error("root iteration count not cleared");

  a_out_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result word raised outside final state");

endmodule

// ===== rtl/core/dead_zone_view_follow_2d.sv =====
// channel  dir  word        handshake
// in_i     in   dzvf_in_t   valid/ready
// out_o    out  dzvf_out_t  valid/ready
// cfg      in   31b data    cfg_we_i, no wait
//
// error item goes from dispatch straight to interpolation, snap item to commit
// follow item: trail then commit, with the speed checks between when limit is on
// follow item with active speed limit also runs the
// 32-step root loop and the 32-step paired divide loop
// one item at a time, the next word is taken only back in idle;
// a held result blocks only the final load
// reset clears centers and the sequencer and sets config to its defaults
module dead_zone_view_follow_2d import dzvf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  dzvf_in_if.sink     in_i,
  dzvf_out_if.source  out_o
);

  dzvf_cmd_t  cmd;
  dzvf_stat_t stat;

  dzvf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dzvf_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_i.data),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_o.data)
  );

endmodule
